// ===== sv/stb_pkg.sv =====
// Shared types, constants and helpers for the sorted table search block.
`timescale 1ns / 1ps
package stb_pkg;

  // Table geometry
  localparam int DEPTH       = 64;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int POS_W       = 6;
  localparam int ENTRY_W     = VAL_W + IDX_W;

  // Command queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field codes
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LOAD_NEW,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             status;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT,
    ST_INSERT,
    ST_RESULT
  } state_t;

  // Load position as reported on the result port (low bits, zero extended)
  function automatic logic [POS_W-1:0] pos_out(input logic [IDX_W-1:0] p);
    return POS_W'(p);
  endfunction

endpackage

// ===== sv/stb_ifs.sv =====
// Valid/ready channel interfaces for item input and result output.
`timescale 1ns / 1ps
interface stb_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic signed [stb_pkg::VAL_W-1:0]  value;
  logic                              start_set;

  modport source(output valid, kind, value, start_set, input ready);
  modport sink(input valid, kind, value, start_set, output ready);
endinterface

interface stb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [stb_pkg::POS_W-1:0]    position;
  logic                         status;

  modport source(output valid, found, position, status, input ready);
  modport sink(input valid, found, position, status, output ready);
endinterface

// ===== sv/stb_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/stb_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
`timescale 1ns / 1ps
module stb_front (
  input  logic          clk,
  input  logic          rst_n,
  stb_in_if.sink        in_ch,
  output logic          cmd_valid,
  output stb_pkg::cmd_t cmd,
  input  logic          cmd_ready
);

  stb_pkg::cmd_t                q_r [stb_pkg::QUEUE_DEPTH];
  logic [stb_pkg::QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [stb_pkg::QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [stb_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         push, pop;
  stb_pkg::cmd_t                cmd_in;

  function automatic logic [stb_pkg::QPTR_W-1:0] ptr_inc(
    input logic [stb_pkg::QPTR_W-1:0] p
  );
    if (p == stb_pkg::QPTR_W'(stb_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // classify: the start mark only matters on loads
  always_comb begin
    cmd_in.value = in_ch.value;
    if (in_ch.kind == stb_pkg::KIND_QUERY) begin
      cmd_in.op = stb_pkg::OP_QUERY;
    end else if (in_ch.start_set) begin
      cmd_in.op = stb_pkg::OP_LOAD_NEW;
    end else begin
      cmd_in.op = stb_pkg::OP_LOAD;
    end
  end

  assign in_ch.ready = (cnt_r != stb_pkg::QCNT_W'(stb_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign cmd         = q_r[rptr_r];
  assign pop         = cmd_valid && cmd_ready;

  always_comb begin
    wptr_nxt = push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt = pop ? ptr_inc(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cmd_in;
    end
  end

endmodule

// ===== sv/stb_back.sv =====
// Back end: binary search, sorted insertion by tail shift, result generation.
`timescale 1ns / 1ps
module stb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  stb_pkg::cmd_t cmd,
  output logic          cmd_ready,
  output logic          res_valid,
  output stb_pkg::res_t res,
  input  logic          res_ready
);

  stb_pkg::state_t               state_r, state_nxt;
  logic [stb_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [stb_pkg::CNT_W-1:0]     loads_r, loads_nxt;
  logic [stb_pkg::CNT_W-1:0]     lo_r, lo_nxt;
  logic [stb_pkg::CNT_W-1:0]     hi_r, hi_nxt;
  logic [stb_pkg::CNT_W-1:0]     mid_r, mid_nxt;
  logic [stb_pkg::CNT_W-1:0]     ptr_r, ptr_nxt;
  logic [stb_pkg::CNT_W-1:0]     mid;
  logic                          hit_r, hit_nxt;
  logic [stb_pkg::IDX_W-1:0]     hpos_r, hpos_nxt;
  stb_pkg::op_t                  op_r, op_nxt;
  logic signed [stb_pkg::VAL_W-1:0] key_r, key_nxt;
  logic                          wr_pend_r, wr_pend_nxt;
  logic [stb_pkg::IDX_W-1:0]     wr_addr_r, wr_addr_nxt;
  stb_pkg::res_t                 res_r, res_nxt;
  logic [stb_pkg::CNT_W-1:0]     eff_loads;

  // RAM ports
  logic                          we;
  logic [stb_pkg::IDX_W-1:0]     waddr, raddr;
  logic [stb_pkg::ENTRY_W-1:0]   wdata, rdata;
  logic signed [stb_pkg::VAL_W-1:0] rd_val;
  logic [stb_pkg::IDX_W-1:0]     rd_pos;

  stb_ram #(
    .WIDTH(stb_pkg::ENTRY_W),
    .DEPTH(stb_pkg::DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  function automatic logic [stb_pkg::IDX_W-1:0] ptr_nxt_dec(
    input logic [stb_pkg::CNT_W-1:0] p
  );
    logic [stb_pkg::CNT_W-1:0] d;
    d = p - 1'b1;
    return d[stb_pkg::IDX_W-1:0];
  endfunction

  assign rd_val    = $signed(rdata[stb_pkg::ENTRY_W-1:stb_pkg::IDX_W]);
  assign rd_pos    = rdata[stb_pkg::IDX_W-1:0];
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign eff_loads = (cmd.op == stb_pkg::OP_LOAD_NEW) ? '0 : loads_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stb_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op != stb_pkg::OP_QUERY &&
              eff_loads >= stb_pkg::CNT_W'(stb_pkg::DEPTH)) begin
            state_nxt = stb_pkg::ST_RESULT;
          end else begin
            state_nxt = stb_pkg::ST_SRCH_RD;
          end
        end
      end
      stb_pkg::ST_SRCH_RD: begin
        if (lo_r < hi_r) begin
          state_nxt = stb_pkg::ST_SRCH_CMP;
        end else if (op_r == stb_pkg::OP_QUERY || hit_r) begin
          state_nxt = stb_pkg::ST_RESULT;
        end else begin
          state_nxt = stb_pkg::ST_SHIFT;
        end
      end
      stb_pkg::ST_SRCH_CMP: state_nxt = stb_pkg::ST_SRCH_RD;
      stb_pkg::ST_SHIFT: begin
        if (ptr_r <= lo_r) begin
          state_nxt = stb_pkg::ST_INSERT;
        end
      end
      stb_pkg::ST_INSERT: state_nxt = stb_pkg::ST_RESULT;
      stb_pkg::ST_RESULT: begin
        if (res_ready) begin
          state_nxt = stb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stb_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt   = count_r;
    loads_nxt   = loads_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    ptr_nxt     = ptr_r;
    hit_nxt     = hit_r;
    hpos_nxt    = hpos_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    wr_pend_nxt = wr_pend_r;
    wr_addr_nxt = wr_addr_r;
    res_nxt     = res_r;
    cmd_ready   = 1'b0;
    res_valid   = 1'b0;
    we          = 1'b0;
    waddr       = wr_addr_r;
    wdata       = rdata;
    raddr       = mid[stb_pkg::IDX_W-1:0];

    unique case (state_r)
      stb_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op_nxt  = cmd.op;
          key_nxt = cmd.value;
          lo_nxt  = '0;
          hit_nxt = 1'b0;
          hi_nxt  = count_r;
          if (cmd.op == stb_pkg::OP_LOAD_NEW) begin
            count_nxt = '0;
            loads_nxt = '0;
            hi_nxt    = '0;
          end
          res_nxt = '{found: 1'b0, position: '0, status: stb_pkg::STATUS_OK};
          if (cmd.op != stb_pkg::OP_QUERY &&
              eff_loads >= stb_pkg::CNT_W'(stb_pkg::DEPTH)) begin
            res_nxt.status = stb_pkg::STATUS_FULL;
          end
        end
      end
      stb_pkg::ST_SRCH_RD: begin
        if (lo_r < hi_r) begin
          mid_nxt = mid;
        end else if (op_r == stb_pkg::OP_QUERY) begin
          res_nxt.found    = hit_r;
          res_nxt.position = hit_r ? stb_pkg::pos_out(hpos_r) : '0;
        end else if (hit_r) begin
          // duplicate value: only the recorded position moves
          we        = 1'b1;
          waddr     = lo_r[stb_pkg::IDX_W-1:0];
          wdata     = {key_r, loads_r[stb_pkg::IDX_W-1:0]};
          loads_nxt = loads_r + 1'b1;
        end else begin
          ptr_nxt     = count_r;
          wr_pend_nxt = 1'b0;
        end
      end
      stb_pkg::ST_SRCH_CMP: begin
        if (rd_val < key_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt   = mid_r;
          hit_nxt  = (rd_val == key_r);
          hpos_nxt = rd_pos;
        end
      end
      stb_pkg::ST_SHIFT: begin
        // read entry ptr-1 now, write it one slot up next cycle
        we = wr_pend_r;
        if (ptr_r > lo_r) begin
          raddr       = ptr_nxt_dec(ptr_r);
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = ptr_r[stb_pkg::IDX_W-1:0];
          ptr_nxt     = ptr_r - 1'b1;
        end else begin
          wr_pend_nxt = 1'b0;
        end
      end
      stb_pkg::ST_INSERT: begin
        we        = 1'b1;
        waddr     = lo_r[stb_pkg::IDX_W-1:0];
        wdata     = {key_r, loads_r[stb_pkg::IDX_W-1:0]};
        count_nxt = count_r + 1'b1;
        loads_nxt = loads_r + 1'b1;
      end
      stb_pkg::ST_RESULT: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= stb_pkg::ST_IDLE;
      count_r   <= '0;
      loads_r   <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      loads_r   <= loads_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    ptr_r     <= ptr_nxt;
    hit_r     <= hit_nxt;
    hpos_r    <= hpos_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    wr_addr_r <= wr_addr_nxt;
    res_r     <= res_nxt;
  end

endmodule

// ===== sv/sorted_table_binary_search.sv =====
// Top level: sorted table with binary search, front queue, back end, output register.
// A query runs a binary search over the table, n = distinct entries held.
// A new load adds a tail shift over slots n..i (i = insertion slot, one RAM read and one
// write per cycle) and then the insert.
// Throughput: one transaction at a time in the back end; the front queue takes input until full.
// Reset (rst_n, synchronous, active low) empties the queue and counts; table RAM is not cleared.
`timescale 1ns / 1ps
module sorted_table_binary_search (
  input  logic       clk,
  input  logic       rst_n,
  stb_in_if.sink     in_ch,
  stb_out_if.source  out_ch
);

  // front -> back command path
  logic          cmd_valid;
  logic          cmd_ready;
  stb_pkg::cmd_t cmd;

  // back -> output register
  logic          res_valid;
  logic          res_ready;
  stb_pkg::res_t res;

  // output register; holds a finished result while the back end moves on
  logic          out_valid_r;
  stb_pkg::res_t out_res_r;

  stb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_ready(cmd_ready)
  );

  stb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_ready(cmd_ready),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready)
  );

  // slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_res_r.found;
  assign out_ch.position = out_res_r.position;
  assign out_ch.status   = out_res_r.status;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the sorted table search block: predictor, stimulus, checker.
`timescale 1ns / 1ps
module tb_top;
  import stb_pkg::*;

  typedef logic signed [VAL_W-1:0] word_t;

  localparam int          CLK_HALF     = 6;          // 12 ns period
  localparam int          RESET_CYCLES = 4;
  localparam int          RANDOM_ITEMS = 680;
  localparam int          HOLD_LEN     = 400;        // long receiver hold-off, in cycles
  localparam int          TAIL_CYCLES  = 2 * DEPTH;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int          REPORT_MAX   = 10;
  localparam word_t       WORD_MIN     = {1'b1, {(VAL_W - 1){1'b0}}};
  localparam word_t       WORD_MAX     = {1'b0, {(VAL_W - 1){1'b1}}};

  logic clk = 1'b0;
  logic rst_n;

  stb_in_if  in_ch ();
  stb_out_if out_ch ();

  sorted_table_binary_search u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow copy of the table, ascending by value, plus the
  // per-set counters. Only slots below n_entries are ever looked at.
  // ---------------------------------------------------------------------------
  word_t       tbl_val [DEPTH];
  int unsigned tbl_pos [DEPTH];
  int          n_entries = 0;   // distinct values held
  int          n_loads   = 0;   // loads accepted in the current set

  // Answers predicted for accepted transactions, oldest first
  res_t predicted_answers[$];

  // Bookkeeping for the summary and the verdict
  int unsigned fail_count     = 0;
  int unsigned n_load_items   = 0;
  int unsigned n_dropped      = 0;
  int unsigned n_query_items  = 0;
  int unsigned n_hits         = 0;
  int unsigned n_results      = 0;
  int unsigned cycle_count    = 0;

  // Idle control: a "fast" side never idles, giving stretches at full rate
  bit          tx_fast = 1'b0;
  bit          rx_fast = 1'b0;
  int unsigned rx_wait = 0;          // receiver stall left for this transaction
  int unsigned rx_hold_cycles = 0;   // long hold-off, counted down in its own process
  event        hold_start;           // kicks off the long hold-off

  // First slot whose value is not below the key; n_entries when none is.
  function automatic int find_slot(word_t key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n_entries;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tbl_val[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Applies one transaction to the shadow table and returns the answer it gives.
  function automatic res_t apply_item(logic kind, word_t value, logic start_set);
    res_t r;
    int   slot;
    r.found    = 1'b0;
    r.position = '0;
    r.status   = STATUS_OK;
    slot = find_slot(value);
    if (kind == KIND_LOAD) begin
      if (start_set) begin
        n_entries = 0;
        n_loads   = 0;
        slot      = 0;
      end
      if (n_loads >= DEPTH) begin
        r.status = STATUS_FULL;   // dropped, table untouched
      end else begin
        if (slot < n_entries && tbl_val[slot] == value) begin
          tbl_pos[slot] = n_loads;   // duplicate: latest load wins
        end else if (n_entries < DEPTH) begin
          // open a hole at the insertion slot
          for (int i = n_entries; i > slot; i--) begin
            tbl_val[i] = tbl_val[i - 1];
            tbl_pos[i] = tbl_pos[i - 1];
          end
          tbl_val[slot] = value;
          tbl_pos[slot] = n_loads;
          n_entries++;
        end
        n_loads++;
      end
    end else if (slot < n_entries && tbl_val[slot] == value) begin
      r.found    = 1'b1;
      r.position = POS_W'(tbl_pos[slot]);
    end
    return r;
  endfunction

  // Value mix: full range, a narrow band around zero, the extremes, and
  // neighbors of what the table already holds (hits, duplicates, near misses).
  function automatic word_t draw_value();
    word_t v;
    case ($urandom_range(0, 5))
      0, 1: v = word_t'($urandom);
      2: v = word_t'(int'($urandom_range(0, 16)) - 8);
      3: begin
        case ($urandom_range(0, 3))
          0: v = WORD_MIN;
          1: v = WORD_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: begin
        if (n_entries > 0)
          v = tbl_val[$urandom_range(0, n_entries - 1)] + word_t'(int'($urandom_range(0, 2)) - 1);
        else
          v = word_t'($urandom);
      end
    endcase
    return v;
  endfunction

  // Search key: mostly something held, otherwise anything from the mix above.
  function automatic word_t draw_key();
    if (n_entries > 0 && $urandom_range(0, 9) < 6)
      return tbl_val[$urandom_range(0, n_entries - 1)];
    return draw_value();
  endfunction

  task automatic report_error(string what, res_t want, res_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t ERROR %s: expected found=%0b position=%0d status=%0b",
               $time, what, want.found, want.position, want.status);
      $display("%0t ERROR %s: got      found=%0b position=%0d status=%0b",
               $time, what, got.found, got.position, got.status);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: random gap, then offer the transaction and hold it until taken.
  // The answer is predicted at the edge where the handshake completes.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic kind, word_t value, logic start_set);
    int   gap;
    res_t want;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.value     <= value;
    in_ch.start_set <= start_set;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = apply_item(kind, value, start_set);
    predicted_answers.push_back(want);
    if (kind == KIND_LOAD) begin
      n_load_items++;
      if (want.status == STATUS_FULL) n_dropped++;
    end else begin
      n_query_items++;
      if (want.found) n_hits++;
    end
  endtask

  // Stop offering and wait until every outstanding answer has come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (predicted_answers.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: after each transaction it draws a random stall; a long
  // hold-off overrides it. Ready gets exactly one assignment per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready)
      rx_wait = rx_fast ? 0 : $urandom_range(0, 19);
    else if (rx_wait != 0)
      rx_wait--;
    out_ch.ready <= (rx_wait == 0) && (rx_hold_cycles == 0);
  end

  // Long hold-off: loaded on request, then counted down one cycle per edge
  always begin
    @(hold_start);
    rx_hold_cycles <= HOLD_LEN;
    repeat (HOLD_LEN) begin
      @(posedge clk);
      rx_hold_cycles <= rx_hold_cycles - 1;
    end
  end

  // Checker: every answer the block hands over is compared with the oldest prediction.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.found    = out_ch.found;
      got.position = out_ch.position;
      got.status   = out_ch.status;
      if (predicted_answers.size() == 0) begin
        report_error("answer with nothing outstanding", '0, got);
      end else begin
        want = predicted_answers.pop_front();
        n_results++;
        if (got.found !== want.found || got.position !== want.position ||
            got.status !== want.status)
          report_error("answer mismatch", want, got);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t timeout with %0d answers outstanding", $time, predicted_answers.size());
      $display("sorted_table_binary_search verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Queries against a table nothing was ever loaded into; a start mark on a
  // query must not matter.
  task automatic test_empty_table();
    send_item(KIND_QUERY, '0, 1'b0);
    send_item(KIND_QUERY, WORD_MIN, 1'b1);
    send_item(KIND_QUERY, WORD_MAX, 1'b0);
  endtask

  // Both ends of the signed range, zero and its neighbors; hits and near misses.
  task automatic test_extremes();
    send_item(KIND_LOAD, WORD_MAX, 1'b1);
    send_item(KIND_LOAD, WORD_MIN, 1'b0);
    send_item(KIND_LOAD, '0, 1'b0);
    send_item(KIND_LOAD, '1, 1'b0);
    send_item(KIND_LOAD, word_t'(1), 1'b0);
    send_item(KIND_QUERY, WORD_MIN, 1'b0);
    send_item(KIND_QUERY, WORD_MAX, 1'b0);
    send_item(KIND_QUERY, '0, 1'b0);
    send_item(KIND_QUERY, '1, 1'b0);
    send_item(KIND_QUERY, word_t'(2), 1'b0);
    send_item(KIND_QUERY, WORD_MAX - 1, 1'b0);
    send_item(KIND_QUERY, WORD_MIN + 1, 1'b0);
  endtask

  // Re-loading a value moves its position; a start mark on a query is ignored,
  // on a load it throws the old set away.
  task automatic test_duplicates_and_restart();
    send_item(KIND_LOAD, '1, 1'b0);
    send_item(KIND_LOAD, WORD_MAX, 1'b0);
    send_item(KIND_QUERY, '1, 1'b1);
    send_item(KIND_QUERY, WORD_MAX, 1'b0);
    send_item(KIND_LOAD, word_t'(7), 1'b1);
    send_item(KIND_QUERY, WORD_MIN, 1'b0);
    send_item(KIND_QUERY, word_t'(7), 1'b0);
  endtask

  // DEPTH loads fill the set; more loads are dropped; a start mark on the full
  // table opens a fresh set at position 0.
  task automatic test_table_full();
    word_t first;
    first = word_t'($urandom);
    send_item(KIND_LOAD, first, 1'b1);
    for (int i = 1; i < DEPTH; i++)
      send_item(KIND_LOAD, (i % 16 == 15) ? first : word_t'($urandom), 1'b0);
    send_item(KIND_LOAD, word_t'($urandom), 1'b0);
    send_item(KIND_LOAD, first, 1'b0);
    send_item(KIND_QUERY, first, 1'b0);
    send_item(KIND_QUERY, tbl_val[n_entries - 1], 1'b0);
    send_item(KIND_LOAD, first, 1'b1);
    send_item(KIND_QUERY, first, 1'b0);
  endtask

  // Receiver holds off while the sender keeps offering at full rate, so the
  // block fills and stalls its input; then the sender pauses until drained.
  task automatic test_backpressure();
    tx_fast = 1'b1;
    -> hold_start;
    send_item(KIND_LOAD, draw_value(), 1'b1);
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) send_item(KIND_QUERY, draw_key(), 1'(i % 2));
      else send_item(KIND_LOAD, draw_value(), 1'b0);
    end
    wait_idle();
    tx_fast = 1'b0;
  endtask

  // Random sets: mostly a start-marked load followed by loads and queries,
  // sometimes a set that runs past full, sometimes a set that goes on without
  // a start mark or is broken off by a stray restart.
  task automatic test_random_sets();
    int sent;
    int set_loads;
    int loads_done;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) tx_fast = !tx_fast;
      if ($urandom_range(0, 5) == 0) rx_fast = !rx_fast;
      set_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 8)
                                              : $urandom_range(1, 20);
      send_item(KIND_LOAD, draw_value(), $urandom_range(0, 5) != 0);
      sent++;
      loads_done = 1;
      while (loads_done < set_loads) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            send_item(KIND_LOAD, draw_value(), $urandom_range(0, 40) == 0);
            loads_done++;
          end
          5, 6, 7, 8: send_item(KIND_QUERY, draw_key(), 1'($urandom_range(0, 1)));
          default: send_item(KIND_QUERY, word_t'($urandom), 1'($urandom_range(0, 1)));
        endcase
        sent++;
      end
      // a few lookups once the set is complete
      repeat ($urandom_range(1, 4)) begin
        send_item(KIND_QUERY, draw_key(), 1'b0);
        sent++;
      end
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_LOAD;
    in_ch.value     <= '0;
    in_ch.start_set <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_extremes();
    test_duplicates_and_restart();
    test_table_full();
    test_backpressure();
    test_random_sets();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d loads (%0d dropped on a full table) and %0d queries (%0d hits).",
             n_load_items, n_dropped, n_query_items, n_hits);
    $display("%0d answers checked over %0d cycles, %0d errors.",
             n_results, cycle_count, fail_count);
    if (fail_count == 0 && predicted_answers.size() == 0)
      $display("sorted_table_binary_search verification clean");
    else
      $display("sorted_table_binary_search verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/stb_pkg.sv
sv/stb_ifs.sv
sv/stb_ram.sv
sv/stb_front.sv
sv/stb_back.sv
sv/sorted_table_binary_search.sv
sim/tb_top.sv
